>>> rtl/core/mpc_pkg.sv
package mpc_pkg;

   localparam int MAX_LEN   = 4096;
   localparam int LEN_W     = 12;
   localparam int CNT_W     = 12;
   localparam int ADDR_W    = $clog2(MAX_LEN);
   // wide enough for any position, any length and MAX_LEN itself
   localparam int CALC_W    = ((ADDR_W > LEN_W) ? ADDR_W : LEN_W) + 1;
   localparam int NUM_CELLS = 3;
   localparam int IDX_W     = 2;

   typedef struct packed {
      logic             ok;
      logic [CNT_W-1:0] cnt;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } wr_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } bypass_type;

   typedef enum logic [IDX_W-1:0] {
      REG_LENGTH_ONE   = 2'd0,
      REG_LENGTH_TWO   = 2'd1,
      REG_LENGTH_THREE = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

endpackage

>>> rtl/core/mpc_cell.sv
module mpc_cell (
   input  logic                       clock,
   input  logic [mpc_pkg::LEN_W-1:0]  piece_len,
   input  logic [mpc_pkg::ADDR_W-1:0] issue_pos,
   input  mpc_pkg::wr_type            wr,
   input  mpc_pkg::bypass_type        last_wr,
   input  mpc_pkg::entry_type         best_in,
   output mpc_pkg::entry_type         best_out
);

   // private copy of the table, so each cell has its own read port
   mpc_pkg::entry_type mem [mpc_pkg::MAX_LEN];

   logic [mpc_pkg::CALC_W-1:0] pos_ext;
   logic [mpc_pkg::CALC_W-1:0] len_ext;
   logic [mpc_pkg::CALC_W-1:0] diff;
   logic [mpc_pkg::ADDR_W-1:0] raddr_in;
   logic                       usable_in;

   mpc_pkg::entry_type         rdata_ff;
   logic [mpc_pkg::ADDR_W-1:0] raddr_ff;
   logic                       usable_ff;

   mpc_pkg::entry_type         near;
   logic                       cand_ok;
   logic [mpc_pkg::CNT_W-1:0]  cand_cnt;

   always_comb begin
      pos_ext   = mpc_pkg::CALC_W'(issue_pos);
      len_ext   = mpc_pkg::CALC_W'(piece_len);
      diff      = pos_ext - len_ext;
      raddr_in  = diff[mpc_pkg::ADDR_W-1:0];
      usable_in = (piece_len != '0) && (len_ext <= pos_ext);
   end

   always_ff @(posedge clock) begin
      rdata_ff  <= mem[raddr_in];
      raddr_ff  <= raddr_in;
      usable_ff <= usable_in;
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_comb begin
      // the entry written in the same cycle as the read is not yet in the memory
      near     = (raddr_ff == last_wr.addr) ? last_wr.data : rdata_ff;
      cand_ok  = usable_ff && near.ok;
      cand_cnt = near.cnt + mpc_pkg::CNT_W'(1);
      if (cand_ok && (!best_in.ok || (cand_cnt > best_in.cnt))) begin
         best_out.ok  = 1'b1;
         best_out.cnt = cand_cnt;
      end else begin
         best_out = best_in;
      end
   end

endmodule

>>> rtl/core/max_piece_count_dp.sv
// channel   direction  handshake              payload
// req       in         start & !busy          req_target_length
// rsp       out        rsp_valid, one cycle   rsp_piece_count, rsp_possible
// csr       in         csr_valid & csr_ready  csr_index, csr_wdata
//
// an item of target t (1 <= t < MAX_LEN) keeps busy high up to and including the
// cycle its result strobes in; target 0 or beyond the table skips the sweep
// the result comes from the sweep over lengths 1..t, one entry per cycle through
// the row of cells, with the last written entry bypassed around the memories
// synchronous reset returns to idle and sets all three lengths to 1
// the receiver cannot stall; csr_ready is always high
module max_piece_count_dp (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [mpc_pkg::LEN_W-1:0]  req_target_length,
   output logic                       rsp_valid,
   output logic [mpc_pkg::CNT_W-1:0]  rsp_piece_count,
   output logic                       rsp_possible,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [mpc_pkg::IDX_W-1:0]  csr_index,
   input  logic [mpc_pkg::LEN_W-1:0]  csr_wdata
);

   mpc_pkg::state_type          state_ff, state_in;
   logic [mpc_pkg::LEN_W-1:0]   target_ff, target_in;
   logic [mpc_pkg::ADDR_W-1:0]  iss_pos_ff, iss_pos_in;
   logic                        iss_active_ff, iss_active_in;
   logic                        s1_valid_ff, s1_valid_in;
   logic [mpc_pkg::ADDR_W-1:0]  s1_pos_ff, s1_pos_in;
   mpc_pkg::entry_type          result_ff, result_in;
   mpc_pkg::bypass_type         last_ff;
   logic [mpc_pkg::LEN_W-1:0]   len_ff [mpc_pkg::NUM_CELLS];

   mpc_pkg::wr_type             wr;
   mpc_pkg::entry_type          chain [mpc_pkg::NUM_CELLS+1];
   mpc_pkg::entry_type          base_entry;
   logic                        accept;
   logic                        in_range;
   logic [mpc_pkg::CALC_W-1:0]  req_ext;

   assign csr_ready       = 1'b1;
   assign busy            = (state_ff != mpc_pkg::ST_IDLE);
   assign rsp_valid       = (state_ff == mpc_pkg::ST_DONE);
   assign rsp_piece_count = result_ff.cnt;
   assign rsp_possible    = result_ff.ok;
   assign accept          = start && !busy;
   assign chain[0]        = '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mpc_pkg::NUM_CELLS; i++) begin
            len_ff[i] <= mpc_pkg::LEN_W'(1);
         end
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mpc_pkg::REG_LENGTH_ONE:   len_ff[0] <= csr_wdata;
            mpc_pkg::REG_LENGTH_TWO:   len_ff[1] <= csr_wdata;
            mpc_pkg::REG_LENGTH_THREE: len_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   for (genvar g = 0; g < mpc_pkg::NUM_CELLS; g++) begin : g_cell
      mpc_cell u_cell (
         .clock     (clock),
         .piece_len (len_ff[g]),
         .issue_pos (iss_pos_ff),
         .wr        (wr),
         .last_wr   (last_ff),
         .best_in   (chain[g]),
         .best_out  (chain[g+1])
      );
   end

   always_comb begin
      base_entry.ok  = 1'b1;
      base_entry.cnt = '0;
      req_ext        = mpc_pkg::CALC_W'(req_target_length);
      in_range       = req_ext < mpc_pkg::CALC_W'(mpc_pkg::MAX_LEN);

      state_in      = state_ff;
      target_in     = target_ff;
      iss_pos_in    = iss_pos_ff;
      iss_active_in = iss_active_ff;
      s1_valid_in   = 1'b0;
      s1_pos_in     = iss_pos_ff;
      result_in     = result_ff;
      wr            = '0;

      unique case (state_ff)
         mpc_pkg::ST_IDLE: begin
            if (accept) begin
               target_in = req_target_length;
               if (!in_range) begin
                  result_in = '0;
                  state_in  = mpc_pkg::ST_DONE;
               end else begin
                  // length 0 is reachable with no pieces
                  wr.en   = 1'b1;
                  wr.addr = '0;
                  wr.data = base_entry;
                  if (req_target_length == '0) begin
                     result_in = base_entry;
                     state_in  = mpc_pkg::ST_DONE;
                  end else begin
                     iss_pos_in    = mpc_pkg::ADDR_W'(1);
                     iss_active_in = 1'b1;
                     state_in      = mpc_pkg::ST_RUN;
                  end
               end
            end
         end
         mpc_pkg::ST_RUN: begin
            if (iss_active_ff) begin
               s1_valid_in = 1'b1;
               iss_pos_in  = iss_pos_ff + mpc_pkg::ADDR_W'(1);
               if (mpc_pkg::CALC_W'(iss_pos_ff) == mpc_pkg::CALC_W'(target_ff)) begin
                  iss_active_in = 1'b0;
               end
            end
            if (s1_valid_ff) begin
               wr.en   = 1'b1;
               wr.addr = s1_pos_ff;
               wr.data = chain[mpc_pkg::NUM_CELLS];
               if (mpc_pkg::CALC_W'(s1_pos_ff) == mpc_pkg::CALC_W'(target_ff)) begin
                  result_in = chain[mpc_pkg::NUM_CELLS];
                  state_in  = mpc_pkg::ST_DONE;
               end
            end
         end
         mpc_pkg::ST_DONE: begin
            state_in = mpc_pkg::ST_IDLE;
         end
         default: begin
            state_in = mpc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mpc_pkg::ST_IDLE;
         iss_active_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         iss_active_ff <= iss_active_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff  <= target_in;
      iss_pos_ff <= iss_pos_in;
      s1_pos_ff  <= s1_pos_in;
      result_ff  <= result_in;
      if (wr.en) begin
         last_ff.addr <= wr.addr;
         last_ff.data <= wr.data;
      end
   end

   a_stage_in_run: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff || iss_active_ff) |-> (state_ff == mpc_pkg::ST_RUN))
      else $error("sweep active outside the run state");

   a_stage_in_bounds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (mpc_pkg::CALC_W'(s1_pos_ff) <= mpc_pkg::CALC_W'(target_ff)))
      else $error("entry written past the target");

   a_done_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mpc_pkg::ST_DONE) |=> (state_ff == mpc_pkg::ST_IDLE))
      else $error("result strobe longer than one cycle");

   a_no_count_when_impossible: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_possible) |-> (rsp_piece_count == '0))
      else $error("count given for an impossible target");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("item accepted without going busy");

endmodule
